### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define TM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tmerge_pkg.sv
package tmerge_pkg;

   // Default capacity in merged streams.
   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam int ARITY                = 4;
   localparam int LEVELS               = 4;
   localparam int COUNT_W              = 7;
   localparam int SCORE_W              = 31;
   localparam int SEG_W                = 6;
   // Stored stream tags can reach one less than the widest count.
   localparam int ENTRY_SEG_W          = 7;

   // Command codes.
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_REFILL = 2'd2;

   typedef struct packed {
      logic [SCORE_W-1:0]     score;
      logic [ENTRY_SEG_W-1:0] seg;
   } entry_type;

   // One tree node: entry 0 is the best.
   typedef entry_type [ARITY-1:0] row_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [SEG_W-1:0]   segment;
      logic [SCORE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] top_score;
      logic [SEG_W-1:0]   top_segment;
      logic               merge_done;
   } rsp_type;

endpackage

### rtl/tmerge_node_unit.sv
module tmerge_node_unit (
   input  logic              op_sort,
   input  tmerge_pkg::row_type row_in,
   output tmerge_pkg::row_type row_out
);

   logic [1:0]          rank [tmerge_pkg::ARITY];
   tmerge_pkg::row_type sorted;
   tmerge_pkg::row_type bubbled;

   // Stable descending rank: entries with a higher score, or an equal score
   // further up the row, come first.
   always_comb begin
      logic [2:0] cnt;
      for (int i = 0; i < tmerge_pkg::ARITY; i++) begin
         cnt = 3'd0;
         for (int j = 0; j < tmerge_pkg::ARITY; j++) begin
            if (j != i) begin
               if ((row_in[j].score > row_in[i].score) ||
                   ((row_in[j].score == row_in[i].score) && (j < i))) begin
                  cnt = cnt + 3'd1;
               end
            end
         end
         rank[i] = cnt[1:0];
      end
   end

   // Place each entry at its rank.
   always_comb begin
      sorted = row_in;
      for (int r = 0; r < tmerge_pkg::ARITY; r++) begin
         for (int i = 0; i < tmerge_pkg::ARITY; i++) begin
            if (rank[i] == 2'(r)) begin
               sorted[r] = row_in[i];
            end
         end
      end
   end

   // Move the first entry down past every entry with a strictly higher score.
   always_comb begin
      tmerge_pkg::entry_type low;
      low = row_in[0];
      for (int j = 1; j < tmerge_pkg::ARITY; j++) begin
         if (low.score >= row_in[j].score) begin
            bubbled[j-1] = low;
            low          = row_in[j];
         end else begin
            bubbled[j-1] = row_in[j];
         end
      end
      bubbled[tmerge_pkg::ARITY-1] = low;
   end

   assign row_out = op_sort ? sorted : bubbled;

endmodule

### rtl/four_ary_tournament_merge_top.sv
// Channel   | Direction | Handshake             | Payload
// req_      | in        | req_valid / req_ready | tmerge_pkg::req_type
// rsp_      | out       | rsp_valid / rsp_ready | tmerge_pkg::rsp_type
// csr_      | in        | csr_valid / csr_ready | segment_count, 7 bits
//
// One shared node unit (stable sort of four, or bubble of the first entry)
// works on one tree node per step; node rows sit in a memory read one row a cycle.
// Load reads the leaf row, then writes the score in; refill checks the root row,
// then bubbles one node per level up to the root. Build sorts each leaf node, then gathers and sorts each upper node.
// req_ready is low while busy and while a finished top waits for the result register.
// Reset clears control state; node rows are undefined until built or loaded.
module four_ary_tournament_merge_top #(
   parameter int MAX_SEGMENTS = tmerge_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tmerge_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tmerge_pkg::rsp_type                rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tmerge_pkg::COUNT_W-1:0]     csr_data
);

   localparam int NODE_CAP = MAX_SEGMENTS / 3 + 8;
   localparam int ADDR_W   = $clog2(NODE_CAP);

   typedef enum logic [2:0] {
      S_IDLE, S_LD_WR, S_BL_WR, S_BP_RD, S_BP_CAP, S_BP_WR, S_RF_CHK, S_RF_WR
   } state_type;

   state_type                          state_ff, state_in;
   tmerge_pkg::req_type                req_ff, req_in;
   logic [5:0]                         k_ff, k_in;
   logic [1:0]                         j_ff, j_in;
   logic [1:0]                         lvl_ff, lvl_in;
   logic                               chok_ff, chok_in;
   tmerge_pkg::row_type                acc_ff, acc_in;
   tmerge_pkg::entry_type              carry_ff, carry_in;
   logic                               built_ff, built_in;
   logic [tmerge_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   tmerge_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   tmerge_pkg::entry_type              top_ff, top_in;
   logic                               out_pend_ff, out_pend_in;

   tmerge_pkg::row_type                mem [NODE_CAP];
   tmerge_pkg::row_type                mem_q;
   logic                               rd_en, wr_en;
   logic [ADDR_W-1:0]                  rd_addr, wr_addr;
   tmerge_pkg::row_type                wr_row;

   logic                               node_op_sort;
   tmerge_pkg::row_type                node_in, node_out;

   logic [tmerge_pkg::COUNT_W-1:0]     n_w;
   logic [5:0]                         lvl_cnt [tmerge_pkg::LEVELS];
   logic [6:0]                         lvl_start [tmerge_pkg::LEVELS];

   // Effective stream count, held between one and the capacity.
   always_comb begin
      if (count_ff == '0) begin
         n_w = tmerge_pkg::COUNT_W'(1);
      end else if (int'(count_ff) > MAX_SEGMENTS) begin
         n_w = tmerge_pkg::COUNT_W'(MAX_SEGMENTS);
      end else begin
         n_w = count_ff;
      end
   end

   // Tree shape: node count per level, leaves at level 0, root stored first.
   always_comb begin
      lvl_cnt[0] = 6'(({1'b0, n_w} + 8'd3) >> 2);
      for (int i = 1; i < tmerge_pkg::LEVELS; i++) begin
         lvl_cnt[i] = (lvl_cnt[i-1] > 6'd1) ? 6'((lvl_cnt[i-1] + 6'd3) >> 2) : 6'd0;
      end
      lvl_start[3] = 7'd0;
      lvl_start[2] = 7'(lvl_cnt[3]);
      lvl_start[1] = 7'(lvl_cnt[3]) + 7'(lvl_cnt[2]);
      lvl_start[0] = 7'(lvl_cnt[3]) + 7'(lvl_cnt[2]) + 7'(lvl_cnt[1]);
   end

   tmerge_node_unit u_node (
      .op_sort (node_op_sort),
      .row_in  (node_in),
      .row_out (node_out)
   );

   assign req_ready = (state_ff == S_IDLE) && !out_pend_ff;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: picks the node row, drives the node unit and writes back.
   always_comb begin
      logic [7:0] leaf;
      logic [7:0] ch;
      logic [7:0] chn;
      state_in     = state_ff;
      req_in       = req_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      lvl_in       = lvl_ff;
      chok_in      = chok_ff;
      acc_in       = acc_ff;
      carry_in     = carry_ff;
      built_in     = built_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      out_pend_in  = out_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      node_op_sort = 1'b1;
      node_in      = mem_q;
      wr_row       = node_out;
      leaf         = '0;
      ch           = '0;
      chn          = '0;

      // Result register empties on a transfer, refills from a pending top.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_pend_ff && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.top_score    = top_ff.score;
         rsp_data_in.top_segment  = top_ff.seg[tmerge_pkg::SEG_W-1:0];
         rsp_data_in.merge_done   = (top_ff.score == '0);
         out_pend_in              = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               count_in = csr_data;
               built_in = 1'b0;
            end
            if (req_valid && !out_pend_ff) begin
               req_in = req_data;
               unique case (req_data.cmd)
                  tmerge_pkg::CMD_LOAD: begin
                     if ({1'b0, req_data.segment} < n_w) begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(lvl_start[0] + 7'(req_data.segment >> 2));
                        built_in = 1'b0;
                        state_in = S_LD_WR;
                     end
                  end
                  tmerge_pkg::CMD_BUILD: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(lvl_start[0]);
                     k_in     = '0;
                     lvl_in   = '0;
                     state_in = S_BL_WR;
                  end
                  tmerge_pkg::CMD_REFILL: begin
                     if (built_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_RF_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Write one score into its leaf slot.
         S_LD_WR: begin
            wr_row = mem_q;
            wr_row[req_ff.segment[1:0]].score = req_ff.value;
            wr_row[req_ff.segment[1:0]].seg   = tmerge_pkg::ENTRY_SEG_W'(req_ff.segment);
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(lvl_start[0] + 7'(req_ff.segment >> 2));
            state_in = S_IDLE;
         end

         // Leaf node: retag slots, pad beyond the count, sort.
         S_BL_WR: begin
            node_in = mem_q;
            for (int j = 0; j < tmerge_pkg::ARITY; j++) begin
               leaf = 8'({k_ff, 2'b00}) + 8'(j);
               if (leaf < {1'b0, n_w}) begin
                  node_in[j].seg = tmerge_pkg::ENTRY_SEG_W'(leaf);
               end else begin
                  node_in[j] = '0;
               end
            end
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(lvl_start[0] + 7'(k_ff));
            if (k_ff + 6'd1 < lvl_cnt[0]) begin
               k_in    = k_ff + 6'd1;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(lvl_start[0] + 7'(k_ff) + 7'd1);
            end else if (lvl_cnt[0] == 6'd1) begin
               top_in      = node_out[0];
               out_pend_in = 1'b1;
               built_in    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               lvl_in   = 2'd1;
               k_in     = '0;
               j_in     = '0;
               state_in = S_BP_RD;
            end
         end

         // Upper node: fetch the first child's row.
         S_BP_RD: begin
            ch      = 8'({k_ff, 2'b00});
            chok_in = (ch < 8'(lvl_cnt[lvl_ff - 2'd1]));
            if (chok_in) begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(lvl_start[lvl_ff - 2'd1] + 7'(ch));
            end
            j_in     = '0;
            state_in = S_BP_CAP;
         end

         // Collect each child's best entry, fetching the next child.
         S_BP_CAP: begin
            acc_in[j_ff] = chok_ff ? mem_q[0] : '0;
            if (j_ff != 2'd3) begin
               chn     = 8'({k_ff, 2'b00}) + 8'(j_ff) + 8'd1;
               chok_in = (chn < 8'(lvl_cnt[lvl_ff - 2'd1]));
               if (chok_in) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(lvl_start[lvl_ff - 2'd1] + 7'(chn));
               end
               j_in = j_ff + 2'd1;
            end else begin
               state_in = S_BP_WR;
            end
         end

         // Sort the collected entries into the parent.
         S_BP_WR: begin
            node_in = acc_ff;
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(lvl_start[lvl_ff] + 7'(k_ff));
            if (k_ff + 6'd1 < lvl_cnt[lvl_ff]) begin
               k_in     = k_ff + 6'd1;
               state_in = S_BP_RD;
            end else if (lvl_cnt[lvl_ff] == 6'd1) begin
               top_in      = node_out[0];
               out_pend_in = 1'b1;
               built_in    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               lvl_in   = lvl_ff + 2'd1;
               k_in     = '0;
               state_in = S_BP_RD;
            end
         end

         // Look at the winner; an exhausted tree or a foreign tag repeats it.
         S_RF_CHK: begin
            if ((mem_q[0].score == '0) || (mem_q[0].seg >= n_w)) begin
               top_in      = mem_q[0];
               out_pend_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               k_in     = 6'(mem_q[0].seg >> 2);
               lvl_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(lvl_start[0] + 7'(mem_q[0].seg >> 2));
               state_in = S_RF_WR;
            end
         end

         // Replace the first entry, bubble it, and climb one level.
         S_RF_WR: begin
            node_op_sort = 1'b0;
            node_in      = mem_q;
            if (lvl_ff == '0) begin
               node_in[0].score = req_ff.value;
            end else begin
               node_in[0] = carry_ff;
            end
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(lvl_start[lvl_ff] + 7'(k_ff));
            carry_in = node_out[0];
            if (lvl_cnt[lvl_ff] == 6'd1) begin
               top_in      = node_out[0];
               out_pend_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               lvl_in  = lvl_ff + 2'd1;
               k_in    = k_ff >> 2;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(lvl_start[lvl_ff + 2'd1] + 7'(k_ff >> 2));
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         count_ff     <= tmerge_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         out_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         out_pend_ff  <= out_pend_in;
      end
      req_ff      <= req_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      lvl_ff      <= lvl_in;
      chok_ff     <= chok_in;
      acc_ff      <= acc_in;
      carry_ff    <= carry_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Node memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

endmodule

### rtl/tmerge_checker.sv
`include "assert_macros.svh"

module tmerge_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input tmerge_pkg::req_type            req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input tmerge_pkg::rsp_type            rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [tmerge_pkg::COUNT_W-1:0] csr_data
);

   // A result that is not taken stays offered.
   `TM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

   // The done flag marks an exhausted merge exactly.
   `TM_ASSERT(a_done_flag, clock, reset, rsp_valid |-> (rsp_data.merge_done == (rsp_data.top_score == '0)), "done flag mismatch")

   // A build transfer keeps the block busy for the next cycle.
   `TM_ASSERT(a_build_busy, clock, reset, req_valid && req_ready && (req_data.cmd == tmerge_pkg::CMD_BUILD) |=> !req_ready, "build did not occupy the block")

   // Reset leaves no result on offer.
   `TM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind four_ary_tournament_merge_top tmerge_checker u_tmerge_checker (.*);
